// File: hw/rtl/bsi_pkg.sv
// ----------------------------------------------------------------------------
// bsi_pkg - shared types and constants of the bounded sorted-insert stack
// Action codes, sequencer states and the compare result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bsi_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int VAL_W         = 8;
    localparam int ACT_W         = 3;
    localparam int CNT_OUT_W     = 6;

    // Code 7 is not named; it behaves as a peek through the default arms.
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH        = 3'd0,
        ACT_POP         = 3'd1,
        ACT_SORTED      = 3'd2,
        ACT_SORTED_UNIQ = 3'd3,
        ACT_BOTTOM      = 3'd4,
        ACT_CLEAR       = 3'd5,
        ACT_PEEK        = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_CMP,
        ST_SHIFT,
        ST_SHIFT_WR,
        ST_TOP,
        ST_TOP_WAIT
    } t_state;

    typedef struct packed {
        logic gt;   // operand strictly greater than the stored entry
        logic eq;   // operand equal to the stored entry
    } t_cmp;

endpackage

`default_nettype wire

// File: hw/rtl/bsi_mem.sv
// ----------------------------------------------------------------------------
// bsi_mem - entry store of the stack
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsi_mem
    import bsi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [VAL_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/bsi_cmp.sv
// ----------------------------------------------------------------------------
// bsi_cmp - shared signed comparator
// Compares the held operand against the entry just read from the store.
// ----------------------------------------------------------------------------
`default_nettype none

module bsi_cmp
    import bsi_pkg::*;
(
    input  wire logic signed [VAL_W-1:0] i_a,
    input  wire logic signed [VAL_W-1:0] i_b,
    output t_cmp                         o_res
);

    always_comb begin
        o_res.gt = (i_a > i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule

`default_nettype wire

// File: hw/rtl/bounded_stack_sorted_insert.sv
// ----------------------------------------------------------------------------
// bounded_stack_sorted_insert - bounded stack with sorted and bottom insert
// A small sequencer walks the entry store one entry at a time, sharing one
// signed comparator for the sorted scan and one read port for the shift.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  --------------------------------
//  command   in         start high, busy low   i_action, i_value
//  result    out        o_strobe, one cycle    o_top_value, o_entry_count,
//                                              o_is_empty_flag, o_is_full_flag,
//                                              o_applied
//
// Each command is a transfer at the edge where start is high and busy is low.
// Pop, clear, peek and refused commands pass through the top read states
// ST_TOP and ST_TOP_WAIT to the strobe. An insert adds the final write, a
// read and a compare (ST_SCAN, ST_SCAN_CMP) for every compare of the sorted
// scan (plus one ST_SCAN when the scan reaches the bottom) and a read and a
// write for every entry lifted, through the single store port pair. A unique insert
// that meets an equal entry spends the scan states but has no final write.
// The strobe cycle is idle, so the next command may be taken in it.
// Reset (synchronous, active low) empties the stack; the store itself is not
// cleared, as only entries below the count are ever read.
// The receiver cannot stall: every result is presented for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_sorted_insert
    import bsi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [ACT_W-1:0]        i_action,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_strobe,
    output logic signed [VAL_W-1:0]      o_top_value,
    output logic [CNT_OUT_W-1:0]         o_entry_count,
    output logic                         o_is_empty_flag,
    output logic                         o_is_full_flag,
    output logic                         o_applied
);

    // Store address width and the width of a counter that can hold DEPTH.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state                  r_state, n_state;
    t_action                 r_act, n_act;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [CW-1:0]           r_pos, n_pos;    // insertion slot
    logic [CW-1:0]           r_idx, n_idx;    // slot being filled by the lift
    logic                    r_applied, n_applied;
    logic                    r_strobe, n_strobe;
    logic signed [VAL_W-1:0] r_top, n_top;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    logic [CW-1:0]           w_pos_m1;
    logic [CW-1:0]           w_idx_m1;
    logic [CW-1:0]           w_cnt_m1;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [VAL_W-1:0]        mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic [VAL_W-1:0]        mem_rdata;
    t_cmp                    cmp_res;

    assign w_accept = start && !busy;
    assign w_full   = (r_cnt == CW'(DEPTH));
    assign w_empty  = (r_cnt == '0);
    assign w_pos_m1 = r_pos - 1'b1;
    assign w_idx_m1 = r_idx - 1'b1;
    assign w_cnt_m1 = r_cnt - 1'b1;

    bsi_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bsi_cmp u_cmp (
        .i_a   (r_val),
        .i_b   (signed'(mem_rdata)),
        .o_res (cmp_res)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_action'(i_action))
                        ACT_PUSH, ACT_BOTTOM:        n_state = w_full ? ST_TOP : ST_SHIFT;
                        ACT_SORTED, ACT_SORTED_UNIQ: n_state = w_full ? ST_TOP : ST_SCAN;
                        default:                     n_state = ST_TOP;
                    endcase
                end
            end
            ST_SCAN: begin
                n_state = (r_pos == '0) ? ST_SHIFT : ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (cmp_res.gt) begin
                    n_state = ST_SCAN;
                end else if (r_act == ACT_SORTED_UNIQ && cmp_res.eq) begin
                    n_state = ST_TOP;
                end else begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_state = (r_idx == r_pos) ? ST_TOP : ST_SHIFT_WR;
            end
            ST_SHIFT_WR: n_state = ST_SHIFT;
            ST_TOP:      n_state = ST_TOP_WAIT;
            ST_TOP_WAIT: n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath control and register next values.
    always_comb begin
        n_act     = r_act;
        n_val     = r_val;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_applied = r_applied;
        n_strobe  = 1'b0;
        n_top     = r_top;
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = w_idx_m1[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_act     = t_action'(i_action);
                    n_val     = i_value;
                    n_applied = 1'b0;
                    n_pos     = r_cnt;
                    n_idx     = r_cnt;
                    case (t_action'(i_action))
                        ACT_POP: begin
                            if (!w_empty) begin
                                n_cnt     = w_cnt_m1;
                                n_applied = 1'b1;
                            end
                        end
                        ACT_BOTTOM: begin
                            n_pos = '0;
                        end
                        ACT_CLEAR: begin
                            if (!w_empty) begin
                                n_cnt     = '0;
                                n_applied = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Fetch the entry just below the current slot.
                mem_re    = (r_pos != '0);
                mem_raddr = w_pos_m1[AW-1:0];
            end
            ST_SCAN_CMP: begin
                if (cmp_res.gt) begin
                    n_pos = w_pos_m1;
                end
            end
            ST_SHIFT: begin
                if (r_idx == r_pos) begin
                    // Lift complete: drop the new value into its slot.
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[AW-1:0];
                    mem_wdata = r_val;
                    n_cnt     = r_cnt + 1'b1;
                    n_applied = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = w_idx_m1[AW-1:0];
                end
            end
            ST_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = mem_rdata;
                n_idx     = w_idx_m1;
            end
            ST_TOP: begin
                mem_re    = !w_empty;
                mem_raddr = w_cnt_m1[AW-1:0];
            end
            ST_TOP_WAIT: begin
                n_top    = w_empty ? '0 : signed'(mem_rdata);
                n_strobe = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_strobe  <= 1'b0;
            r_applied <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_strobe  <= n_strobe;
            r_applied <= n_applied;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;
        r_val <= n_val;
        r_pos <= n_pos;
        r_idx <= n_idx;
        r_top <= n_top;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_strobe        = r_strobe;
    assign o_top_value     = r_top;
    assign o_entry_count   = CNT_OUT_W'(r_cnt);
    assign o_is_empty_flag = w_empty;
    assign o_is_full_flag  = w_full;
    assign o_applied       = r_applied;

    // A result is only presented straight after the top entry has been read.
    a_strobe_after_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == ST_TOP_WAIT)
        else $error("result strobe without a preceding top read");

    // The count never exceeds the capacity of the store.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count beyond capacity");

    // An accepted command always makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("command transfer did not start the sequencer");

    // An insert that was applied grows the stack by exactly one entry.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && r_idx == r_pos) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("insert did not grow the stack by one");

endmodule

`default_nettype wire

// File: tb/bounded_stack_sorted_insert_tb.sv
// ----------------------------------------------------------------------------
// bounded_stack_sorted_insert_tb - self-checking bench for the sorted stack
// Drives stack commands through the start/busy handshake, keeps its own copy
// of the stack to predict every result and compares each strobed result
// field by field, under several rates of sender idling.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_sorted_insert_tb;
    import bsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEPTH_DEFAULT;

    // Code 7 has no name in the package; the block treats it as a peek.
    localparam logic [ACT_W-1:0] ACT_SPARE = 3'd7;

    // Action mixes used by the random phases.
    localparam int MIX_FILL    = 0;
    localparam int MIX_BALANCE = 1;
    localparam int MIX_NARROW  = 2;
    localparam int MIX_DRAIN   = 3;

    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 128;

    // One pending command, with the idling rate of its phase and a flag that
    // makes the sender hold off until every outstanding result has come back.
    typedef struct {
        logic [ACT_W-1:0]        action;
        logic signed [VAL_W-1:0] value;
        int                      gap_pct;
        bit                      drain;
    } t_command;

    // One result as the block should strobe it.
    typedef struct {
        logic signed [VAL_W-1:0] top;
        logic [CNT_OUT_W-1:0]    count;
        logic                    empty;
        logic                    full;
        logic                    applied;
    } t_stack_view;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [ACT_W-1:0]             i_action = '0;
    logic signed [VAL_W-1:0]      i_value = '0;
    logic                         o_strobe;
    logic signed [VAL_W-1:0]      o_top_value;
    logic [CNT_OUT_W-1:0]         o_entry_count;
    logic                         o_is_empty_flag;
    logic                         o_is_full_flag;
    logic                         o_applied;

    // Commands waiting to be driven, and the results still owed by the block.
    t_command    command_queue[$];
    t_stack_view expected_views[$];

    // The bench's own copy of the stack: index 0 is the bottom entry.
    logic signed [VAL_W-1:0] shadow_stack [DEPTH];
    int                      shadow_fill = 0;

    int mismatch_count = 0;

    bounded_stack_sorted_insert #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_top_value    (o_top_value),
        .o_entry_count  (o_entry_count),
        .o_is_empty_flag(o_is_empty_flag),
        .o_is_full_flag (o_is_full_flag),
        .o_applied      (o_applied)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Reset is held low from time zero and then released for good.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // A hard ceiling on the run. The slowest legal run, with every insert
    // scanning and lifting a full stack, stays well under a fifth of this.
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void flag_error(string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endfunction

    // Lift the entries from slot upward by one place and write the value into
    // the gap. Callers make sure the stack is not full.
    function automatic void lift_and_place(int slot, logic signed [VAL_W-1:0] value);
        for (int i = shadow_fill; i > slot; i--) begin
            shadow_stack[i] = shadow_stack[i-1];
        end
        shadow_stack[slot] = value;
        shadow_fill++;
    endfunction

    // The slot just below the run of top entries that are strictly smaller
    // than the value, using a signed comparison.
    function automatic int sorted_slot(logic signed [VAL_W-1:0] value);
        int slot;
        slot = shadow_fill;
        while (slot > 0 && value > shadow_stack[slot-1]) begin
            slot--;
        end
        return slot;
    endfunction

    // Apply one accepted command to the shadow stack and queue the result
    // that the block must strobe for it.
    function automatic void apply_stack_op(logic [ACT_W-1:0] action,
                                           logic signed [VAL_W-1:0] value);
        t_stack_view view;
        logic        is_full;
        logic        changed;
        int          slot;
        is_full = (shadow_fill >= DEPTH);
        changed = 1'b0;
        case (action)
            ACT_PUSH: begin
                if (!is_full) begin
                    lift_and_place(shadow_fill, value);
                    changed = 1'b1;
                end
            end
            ACT_POP: begin
                if (shadow_fill > 0) begin
                    shadow_fill--;
                    changed = 1'b1;
                end
            end
            ACT_SORTED: begin
                if (!is_full) begin
                    lift_and_place(sorted_slot(value), value);
                    changed = 1'b1;
                end
            end
            ACT_SORTED_UNIQ: begin
                if (!is_full) begin
                    slot = sorted_slot(value);
                    if (slot == 0 || shadow_stack[slot-1] != value) begin
                        lift_and_place(slot, value);
                        changed = 1'b1;
                    end
                end
            end
            ACT_BOTTOM: begin
                if (!is_full) begin
                    lift_and_place(0, value);
                    changed = 1'b1;
                end
            end
            ACT_CLEAR: begin
                if (shadow_fill > 0) begin
                    shadow_fill = 0;
                    changed = 1'b1;
                end
            end
            default: begin
                // Peek and the spare code leave the stack alone.
            end
        endcase
        view.top     = (shadow_fill > 0) ? shadow_stack[shadow_fill-1] : '0;
        view.count   = shadow_fill[CNT_OUT_W-1:0];
        view.empty   = (shadow_fill == 0);
        view.full    = (shadow_fill >= DEPTH);
        view.applied = changed;
        expected_views.push_back(view);
    endfunction

    function automatic void queue_command(logic [ACT_W-1:0] action,
                                          logic signed [VAL_W-1:0] value,
                                          int gap_pct, bit drain);
        t_command cmd;
        cmd.action  = action;
        cmd.value   = value;
        cmd.gap_pct = gap_pct;
        cmd.drain   = drain;
        command_queue.push_back(cmd);
    endfunction

    // Draw an action according to the mix of the phase. The fill mixes push
    // the stack to full quickly, so refused inserts come up often; the drain
    // mix keeps it near empty, so refused pops and clears come up too.
    function automatic logic [ACT_W-1:0] pick_action(int mix);
        int bound [8];
        int roll;
        case (mix)
            MIX_FILL, MIX_NARROW: bound = '{25, 45, 65, 85, 95, 96, 98, 100};
            MIX_BALANCE:          bound = '{15, 50, 65, 75, 85, 90, 97, 100};
            default:              bound = '{10, 70, 78, 84, 90, 95, 98, 100};
        endcase
        roll = $urandom_range(0, 99);
        for (int i = 0; i < 8; i++) begin
            if (roll < bound[i]) begin
                return i[ACT_W-1:0];
            end
        end
        return ACT_SPARE;
    endfunction

    // Narrow values crowd into a few codes so that equal entries, and with
    // them skipped unique inserts, turn up often; the extremes are mixed in.
    function automatic logic signed [VAL_W-1:0] pick_value(int mix);
        logic signed [VAL_W-1:0] value;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       value = 8'sh7F;
                1:       value = 8'sh80;
                2:       value = 8'sh00;
                default: value = 8'shFF;
            endcase
        end else if (mix == MIX_NARROW) begin
            value = VAL_W'($signed($urandom_range(0, 6)) - 3);
        end else begin
            value = VAL_W'($urandom_range(0, 255));
        end
        return value;
    endfunction

    // Command driver. A transfer happens at the edge where start is high and
    // busy is low; the values sampled here are those the block saw at that
    // edge, so the prediction is made from them. Start is assigned once per
    // edge, so a back-to-back command keeps it high without a glitch.
    always @(posedge i_clk) begin : command_driver
        t_command head;
        logic     launch;
        launch = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_stack_op(i_action, i_value);
                void'(command_queue.pop_front());
            end
            if (start && busy) begin
                // Not yet taken: hold the command as it is.
                launch = 1'b1;
            end else if (command_queue.size() != 0) begin
                head = command_queue[0];
                if (head.drain && expected_views.size() != 0) begin
                    launch = 1'b0;
                end else if ($urandom_range(0, 99) < head.gap_pct) begin
                    launch = 1'b0;
                end else begin
                    launch = 1'b1;
                    i_action <= head.action;
                    i_value  <= head.value;
                end
            end
            start <= launch;
        end
    end

    // Result monitor. The receiver cannot hold the block off, so every strobe
    // is a transfer and is checked against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_stack_view want;
        if (i_rst_n && o_strobe) begin
            if (expected_views.size() == 0) begin
                flag_error($sformatf(
                    "unexpected result: top %0d count %0d empty %0b full %0b applied %0b",
                    o_top_value, o_entry_count, o_is_empty_flag, o_is_full_flag,
                    o_applied));
            end else begin
                want = expected_views.pop_front();
                if (o_top_value !== want.top || o_entry_count !== want.count ||
                    o_is_empty_flag !== want.empty || o_is_full_flag !== want.full ||
                    o_applied !== want.applied) begin
                    flag_error($sformatf(
                        {"mismatch: expected top %0d count %0d empty %0b full %0b ",
                         "applied %0b, got top %0d count %0d empty %0b full %0b applied %0b"},
                        want.top, want.count, want.empty, want.full, want.applied,
                        o_top_value, o_entry_count, o_is_empty_flag, o_is_full_flag,
                        o_applied));
                end
            end
        end
    end

    // Stimulus and the end of the run.
    initial begin : stimulus
        int gap_of_phase [PHASE_COUNT];
        int waited;
        gap_of_phase = '{0, 47, 34, 0, 47, 0, 34, 47};

        // Directed part: empty-stack refusals, the extremes of the value,
        // every action, duplicates for the unique insert and the spare code.
        queue_command(ACT_PEEK,        8'sh00, 0, 1'b1);
        queue_command(ACT_POP,         8'sh00, 0, 1'b0);
        queue_command(ACT_CLEAR,       8'sh00, 0, 1'b0);
        queue_command(ACT_SPARE,       8'sh00, 0, 1'b0);
        queue_command(ACT_PUSH,        8'sh7F, 0, 1'b0);
        queue_command(ACT_PUSH,        8'sh80, 0, 1'b0);
        queue_command(ACT_SORTED,      8'sh00, 0, 1'b0);
        queue_command(ACT_SORTED_UNIQ, 8'sh80, 0, 1'b0);
        queue_command(ACT_SORTED_UNIQ, 8'sh05, 0, 1'b0);
        queue_command(ACT_SORTED,      8'sh7F, 0, 1'b0);
        queue_command(ACT_SORTED_UNIQ, 8'sh7F, 0, 1'b0);
        queue_command(ACT_SORTED_UNIQ, 8'shFF, 0, 1'b0);
        queue_command(ACT_BOTTOM,      8'shFF, 0, 1'b0);
        queue_command(ACT_BOTTOM,      8'sh55, 0, 1'b0);
        queue_command(ACT_PUSH,        8'shAA, 0, 1'b0);
        queue_command(ACT_PEEK,        8'sh7F, 0, 1'b0);
        queue_command(ACT_POP,         8'sh00, 0, 1'b0);
        queue_command(ACT_POP,         8'shFF, 0, 1'b0);
        queue_command(ACT_CLEAR,       8'sh2A, 0, 1'b0);
        queue_command(ACT_SORTED_UNIQ, 8'sh00, 0, 1'b0);
        queue_command(ACT_SORTED,      8'sh01, 0, 1'b0);
        queue_command(ACT_POP,         8'sh80, 0, 1'b0);
        queue_command(ACT_CLEAR,       8'sh13, 0, 1'b0);
        queue_command(ACT_BOTTOM,      8'sh2A, 0, 1'b0);
        queue_command(ACT_SPARE,       8'sh6D, 0, 1'b0);

        // Random phases. Each opens by letting the block drain completely,
        // then runs its own action mix under its own idling rate.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_command(pick_action(p % 4), pick_value(p % 4),
                              gap_of_phase[p], n == 0);
            end
        end

        // Every command must be taken, then every result must come back.
        while (command_queue.size() != 0) begin
            @(negedge i_clk);
        end
        waited = 0;
        while (expected_views.size() != 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        // Let any stray strobe show itself before the verdict.
        repeat (200) @(negedge i_clk);
        if (expected_views.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", expected_views.size()));
        end

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/bsi_pkg.sv
hw/rtl/bsi_mem.sv
hw/rtl/bsi_cmp.sv
hw/rtl/bounded_stack_sorted_insert.sv
tb/bounded_stack_sorted_insert_tb.sv
